FILE: rtl/rprs_pkg.sv
// Package for the reversing PWM ramp sequencer.
// Holds item codes, direction patterns, the ramp phase type and the state and result structs.
// No dependencies.
package rprs_pkg;

   localparam int DutyWidth = 8;
   localparam int CodeWidth = 3;
   localparam int PatWidth  = 4;

   localparam logic FUNC_CMD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [CodeWidth-1:0] CODE_STOP  = 3'd0;
   localparam logic [CodeWidth-1:0] CODE_FWD   = 3'd1;
   localparam logic [CodeWidth-1:0] CODE_BACK  = 3'd2;
   localparam logic [CodeWidth-1:0] CODE_LEFT  = 3'd3;
   localparam logic [CodeWidth-1:0] CODE_RIGHT = 3'd4;

   // Pin order in a pattern: bit 0 FL, bit 1 FR, bit 2 BL, bit 3 BR.
   localparam logic [PatWidth-1:0] PAT_FWD   = 4'h5;
   localparam logic [PatWidth-1:0] PAT_BACK  = 4'hA;
   localparam logic [PatWidth-1:0] PAT_LEFT  = 4'h0;
   localparam logic [PatWidth-1:0] PAT_RIGHT = 4'hF;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_RAMP = 3'b010,
      PH_DOWN = 3'b100
   } phase_type;

   typedef struct packed {
      logic [DutyWidth-1:0] duty_now;
      logic [DutyWidth-1:0] duty_goal;
      logic [PatWidth-1:0]  dir_pattern;
      logic [PatWidth-1:0]  pending_pattern;
      logic [CodeWidth-1:0] last_code;
      phase_type            phase;
   } ramp_state_type;

   typedef struct packed {
      logic [DutyWidth-1:0] duty_out;
      logic [PatWidth-1:0]  dir_pattern;
      logic                 busy_res;
      logic                 rejected;
   } ramp_result_type;

   localparam ramp_state_type RampStateReset = '{
      duty_now:        '0,
      duty_goal:       '0,
      dir_pattern:     '0,
      pending_pattern: '0,
      last_code:       '0,
      phase:           PH_IDLE
   };

endpackage

FILE: rtl/rprs_step.sv
// Next-state and result logic for one beat of the ramp sequencer.
// Depends on rprs_pkg for codes, patterns and the state and result structs.
module rprs_step
   import rprs_pkg::*;
(
   input  logic                 func,
   input  logic [DutyWidth-1:0] target_duty,
   input  logic [CodeWidth-1:0] motion_code,
   input  ramp_state_type       state_cur,
   output ramp_state_type       state_nxt,
   output ramp_result_type      result
);

   logic [PatWidth-1:0]  new_pat;
   logic [DutyWidth-1:0] new_goal;
   logic                 rej;
   logic [DutyWidth-1:0] stepped;

   always_comb begin
      case (motion_code)
         CODE_STOP:  new_pat = PAT_FWD;
         CODE_FWD:   new_pat = PAT_FWD;
         CODE_BACK:  new_pat = PAT_BACK;
         CODE_LEFT:  new_pat = PAT_LEFT;
         CODE_RIGHT: new_pat = PAT_RIGHT;
         default:    new_pat = state_cur.dir_pattern;
      endcase
   end

   assign new_goal = (motion_code == CODE_STOP) ? '0 : target_duty;

   always_comb begin
      if (state_cur.duty_now < state_cur.duty_goal) begin
         stepped = state_cur.duty_now + 1'b1;
      end else if (state_cur.duty_now > state_cur.duty_goal) begin
         stepped = state_cur.duty_now - 1'b1;
      end else begin
         stepped = state_cur.duty_now;
      end
   end

   always_comb begin
      state_nxt = state_cur;
      rej       = 1'b0;
      if (func == FUNC_CMD) begin
         if (state_cur.phase == PH_RAMP || state_cur.phase == PH_DOWN) begin
            rej = 1'b1;
         end else begin
            state_nxt.duty_goal = new_goal;
            state_nxt.last_code = motion_code;
            if (state_cur.last_code != CODE_STOP && state_cur.last_code != motion_code &&
                state_cur.duty_now != '0) begin
               state_nxt.pending_pattern = new_pat;
               state_nxt.phase           = PH_DOWN;
            end else begin
               state_nxt.dir_pattern = new_pat;
               state_nxt.phase = (state_cur.duty_now == new_goal) ? PH_IDLE : PH_RAMP;
            end
         end
      end else begin
         case (state_cur.phase)
            PH_RAMP: begin
               state_nxt.duty_now = stepped;
               state_nxt.phase = (stepped == state_cur.duty_goal) ? PH_IDLE : PH_RAMP;
            end
            PH_DOWN: begin
               if (state_cur.duty_now <= 8'd1) begin
                  state_nxt.duty_now    = '0;
                  state_nxt.dir_pattern = state_cur.pending_pattern;
                  state_nxt.phase = (state_cur.duty_goal == '0) ? PH_IDLE : PH_RAMP;
               end else begin
                  state_nxt.duty_now = state_cur.duty_now - 1'b1;
               end
            end
            default: begin
               state_nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

   assign result.duty_out    = state_nxt.duty_now;
   assign result.dir_pattern = state_nxt.dir_pattern;
   assign result.busy_res    = (state_nxt.phase == PH_RAMP) || (state_nxt.phase == PH_DOWN);
   assign result.rejected    = rej;

endmodule

FILE: rtl/reversing_pwm_ramp_sequencer.sv
// Reversing PWM ramp sequencer, top level: an input register, the step logic and a result register.
// A beat passes from the input register through the step logic into the result register.
// One beat per cycle unless rsp_stall holds it; the ramp state feeds back through one register.
// Reset (synchronous, active high) empties both stages, sets duty 0, all pins low, phase idle.
// Depends on rprs_pkg and rprs_step.
module reversing_pwm_ramp_sequencer
   import rprs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [DutyWidth-1:0] req_target_duty,
   input  logic [CodeWidth-1:0] req_motion_code,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DutyWidth-1:0] rsp_duty_out,
   output logic                 rsp_dir_front_left,
   output logic                 rsp_dir_front_right,
   output logic                 rsp_dir_back_left,
   output logic                 rsp_dir_back_right,
   output logic                 rsp_busy_res,
   output logic                 rsp_rejected
);

   logic                 in_valid_ff;
   logic                 func_ff;
   logic [DutyWidth-1:0] target_ff;
   logic [CodeWidth-1:0] code_ff;
   logic                 out_valid_ff;
   ramp_result_type      result_ff;
   ramp_state_type       state_ff;
   ramp_state_type       state_in;
   ramp_result_type      result_in;
   logic                 out_free;
   logic                 advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   rprs_step u_step (
      .func        (func_ff),
      .target_duty (target_ff),
      .motion_code (code_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= RampStateReset;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         func_ff   <= req_func;
         target_ff <= req_target_duty;
         code_ff   <= req_motion_code;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_duty_out        = result_ff.duty_out;
   assign rsp_dir_front_left  = result_ff.dir_pattern[0];
   assign rsp_dir_front_right = result_ff.dir_pattern[1];
   assign rsp_dir_back_left   = result_ff.dir_pattern[2];
   assign rsp_dir_back_right  = result_ff.dir_pattern[3];
   assign rsp_busy_res        = result_ff.busy_res;
   assign rsp_rejected        = result_ff.rejected;

endmodule

FILE: dv/reversing_pwm_ramp_sequencer_test.sv
// Self-checking testbench for the reversing PWM ramp sequencer: directed ramp, reject and
// reversal cases, then random command and tick traffic with random gaps and stalls.
// Depends on rprs_pkg and the reversing_pwm_ramp_sequencer RTL.
`timescale 1ns / 1ps

module reversing_pwm_ramp_sequencer_test;
   import rprs_pkg::*;

   localparam int QuietLimit = 2000;
   localparam logic [CodeWidth-1:0] CODE_KEEP_FIRST = 3'd5;
   localparam logic [CodeWidth-1:0] CODE_KEEP_LAST  = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = FUNC_TICK;
   logic [DutyWidth-1:0] req_target_duty = '0;
   logic [CodeWidth-1:0] req_motion_code = CODE_STOP;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DutyWidth-1:0] rsp_duty_out;
   logic                 rsp_dir_front_left;
   logic                 rsp_dir_front_right;
   logic                 rsp_dir_back_left;
   logic                 rsp_dir_back_right;
   logic                 rsp_busy_res;
   logic                 rsp_rejected;

   reversing_pwm_ramp_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_target_duty     (req_target_duty),
      .req_motion_code     (req_motion_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty_out        (rsp_duty_out),
      .rsp_dir_front_left  (rsp_dir_front_left),
      .rsp_dir_front_right (rsp_dir_front_right),
      .rsp_dir_back_left   (rsp_dir_back_left),
      .rsp_dir_back_right  (rsp_dir_back_right),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_rejected        (rsp_rejected)
   );

   logic [DutyWidth-1:0] duty_q = '0;
   logic [DutyWidth-1:0] goal_q = '0;
   logic [PatWidth-1:0]  pat_q = '0;
   logic [PatWidth-1:0]  pending_pat_q = '0;
   logic [CodeWidth-1:0] last_code_q = CODE_STOP;
   phase_type            phase_q = PH_IDLE;

   ramp_result_type awaited_results[$];
   int              mismatch_count = 0;
   int              live_items = 0;
   int              quiet_cycles = 0;
   int              stall_left = 0;
   bit              idle_on = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PatWidth-1:0] pattern_of(logic [CodeWidth-1:0] code);
      case (code)
         CODE_STOP, CODE_FWD: return PAT_FWD;
         CODE_BACK: return PAT_BACK;
         CODE_LEFT: return PAT_LEFT;
         CODE_RIGHT: return PAT_RIGHT;
         default: return pat_q;
      endcase
   endfunction

   function automatic ramp_result_type ramp_next_result(logic func,
                                                       logic [DutyWidth-1:0] target,
                                                       logic [CodeWidth-1:0] code);
      ramp_result_type res;
      logic [PatWidth-1:0] next_pat;
      res.rejected = 1'b0;
      if (func == FUNC_CMD) begin
         if (phase_q != PH_IDLE) begin
            res.rejected = 1'b1;
         end else begin
            next_pat = pattern_of(code);
            goal_q = (code == CODE_STOP) ? '0 : target;
            if (last_code_q != CODE_STOP && last_code_q != code && duty_q != 0) begin
               pending_pat_q = next_pat;
               phase_q = PH_DOWN;
            end else begin
               pat_q = next_pat;
               phase_q = (duty_q == goal_q) ? PH_IDLE : PH_RAMP;
            end
            last_code_q = code;
         end
      end else if (phase_q == PH_RAMP) begin
         if (duty_q < goal_q) begin
            duty_q = duty_q + 8'd1;
         end else if (duty_q > goal_q) begin
            duty_q = duty_q - 8'd1;
         end
         phase_q = (duty_q == goal_q) ? PH_IDLE : PH_RAMP;
      end else if (phase_q == PH_DOWN) begin
         if (duty_q != 0) begin
            duty_q = duty_q - 8'd1;
         end
         if (duty_q == 0) begin
            pat_q = pending_pat_q;
            phase_q = (goal_q == 0) ? PH_IDLE : PH_RAMP;
         end
      end
      res.duty_out = duty_q;
      res.dir_pattern = pat_q;
      res.busy_res = (phase_q != PH_IDLE);
      return res;
   endfunction

   function automatic void check_field(string label, logic [DutyWidth-1:0] want,
                                       logic [DutyWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      ramp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got duty %0d",
                     $time, rsp_duty_out);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("duty_out", want.duty_out, rsp_duty_out);
            check_field("dir_front_left", DutyWidth'(want.dir_pattern[0]),
                        DutyWidth'(rsp_dir_front_left));
            check_field("dir_front_right", DutyWidth'(want.dir_pattern[1]),
                        DutyWidth'(rsp_dir_front_right));
            check_field("dir_back_left", DutyWidth'(want.dir_pattern[2]),
                        DutyWidth'(rsp_dir_back_left));
            check_field("dir_back_right", DutyWidth'(want.dir_pattern[3]),
                        DutyWidth'(rsp_dir_back_right));
            check_field("busy_res", DutyWidth'(want.busy_res), DutyWidth'(rsp_busy_res));
            check_field("rejected", DutyWidth'(want.rejected), DutyWidth'(rsp_rejected));
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_beat(logic func, logic [DutyWidth-1:0] target,
                            logic [CodeWidth-1:0] code);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_target_duty = target;
      req_motion_code = code;
      do @(posedge clock); while (req_stall);
      live_items++;
      awaited_results.push_back(ramp_next_result(func, target, code));
   endtask

   task automatic send_tick();
      send_beat(FUNC_TICK, DutyWidth'($urandom_range(0, 255)),
                CodeWidth'($urandom_range(0, 7)));
   endtask

   task automatic tick_until_settled();
      while (phase_q != PH_IDLE) send_tick();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_ticks();
      send_tick();
      send_tick();
   endtask

   task automatic test_stop_code();
      send_beat(FUNC_CMD, 8'd255, CODE_STOP);
   endtask

   task automatic test_forward_ramp();
      send_beat(FUNC_CMD, 8'd3, CODE_FWD);
      tick_until_settled();
      send_tick();
   endtask

   task automatic test_busy_reject();
      send_beat(FUNC_CMD, 8'd5, CODE_FWD);
      send_beat(FUNC_CMD, 8'd255, CODE_BACK);
      tick_until_settled();
   endtask

   task automatic test_reversal();
      send_beat(FUNC_CMD, 8'd1, CODE_BACK);
      tick_until_settled();
   endtask

   task automatic test_keep_code();
      send_beat(FUNC_CMD, 8'd0, CODE_KEEP_LAST);
      tick_until_settled();
   endtask

   task automatic test_reversal_at_zero();
      send_beat(FUNC_CMD, 8'd0, CODE_RIGHT);
      send_beat(FUNC_CMD, 8'd0, CODE_LEFT);
      send_beat(FUNC_CMD, 8'd0, CODE_KEEP_FIRST);
   endtask

   // Mostly a command from idle followed by ticks, with rejected commands and noise mixed in.
   task automatic test_random_traffic(int stop_at);
      logic [DutyWidth-1:0] target;
      int                   ticks;
      while (live_items < stop_at) begin
         if ($urandom_range(0, 99) < 80) begin
            tick_until_settled();
            target = ($urandom_range(0, 7) == 0) ? DutyWidth'($urandom_range(0, 255))
                                                 : DutyWidth'($urandom_range(0, 12));
            send_beat(FUNC_CMD, target, CodeWidth'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0) begin
               tick_until_settled();
            end else begin
               ticks = $urandom_range(1, 12);
               repeat (ticks) begin
                  send_tick();
                  if ($urandom_range(0, 9) == 0) begin
                     send_beat(FUNC_CMD, DutyWidth'($urandom_range(0, 255)),
                               CodeWidth'($urandom_range(0, 7)));
                  end
               end
            end
         end else begin
            send_beat(1'($urandom_range(0, 1)), DutyWidth'($urandom_range(0, 255)),
                      CodeWidth'($urandom_range(0, 7)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_idle_ticks();
      test_stop_code();
      test_forward_ramp();
      wait_drained();
      test_busy_reject();
      test_reversal();
      test_keep_code();
      test_reversal_at_zero();
      wait_drained();
      test_random_traffic(580);
      wait_drained();
      idle_on = 1'b0;
      test_random_traffic(700);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
